@@ sv/mexp_pkg.sv @@
// Shared constants and types for the modular exponentiation block.
package mexp_pkg;
    localparam int EXP_BITS = 32;
    localparam int MOD_BITS = 32;
    localparam int DATA_W   = 32;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int CNT_W    = $clog2(PROD_W + 1);
    localparam int ECNT_W   = $clog2(EXP_BITS + 1);

    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] expo;
        logic [DATA_W-1:0] modulus;
        logic              zero_mod;
    } t_job;
endpackage

@@ sv/mexp_front.sv @@
// Front end: accepts words, masks and classifies them, two-entry job queue.
module mexp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [31:0]    i_base_value,
    input  logic [31:0]    i_exponent_value,
    input  logic [31:0]    i_modulus_value,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output mexp_pkg::t_job o_job
);
    import mexp_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job       w_in;
    logic       w_push, w_pop;
    logic [DATA_W-1:0] w_mod;
    logic [DATA_W-1:0] w_exp;

    always_comb begin
        w_mod = i_modulus_value & DATA_W'((65'd1 << MOD_BITS) - 65'd1);
        w_exp = i_exponent_value & DATA_W'((65'd1 << EXP_BITS) - 65'd1);
        w_in.base     = i_base_value;
        w_in.expo     = w_exp;
        w_in.modulus  = w_mod;
        w_in.zero_mod = (w_mod == '0);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_in;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

@@ sv/mexp_reduce.sv @@
// Shared multiply-and-reduce unit: 32x32 product, then bit-serial remainder.
module mexp_reduce (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    input  logic              i_mul,
    input  logic [31:0]       i_m,
    output logic              o_done,
    output logic [31:0]       o_r
);
    import mexp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} t_st;
    t_st                 r_st;
    logic [PROD_W-1:0]   r_p;
    logic [DATA_W-1:0]   r_a, r_b, r_m;
    logic                r_mul;
    logic [DATA_W:0]     r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic [DATA_W:0]     w_sh;
    logic [DATA_W:0]     w_sub;

    assign w_sh  = {r_rem[DATA_W-1:0], r_p[PROD_W-1]};
    assign w_sub = w_sh - {1'b0, r_m};
    assign o_r   = r_rem[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_st)
                S_IDLE: if (i_start) begin
                    r_a <= i_a; r_b <= i_b; r_m <= i_m; r_mul <= i_mul;
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_p   <= r_mul ? PROD_W'(r_a) * PROD_W'(r_b) : PROD_W'(r_a);
                    r_rem <= '0;
                    r_cnt <= CNT_W'(PROD_W);
                    r_st  <= S_DIV;
                end
                S_DIV: begin
                    r_p   <= r_p << 1;
                    r_rem <= w_sub[DATA_W] ? w_sh : w_sub;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_st   <= S_IDLE;
                        o_done <= 1'b1;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/mexp_back.sv @@
// Back end: square-and-multiply sequencer over the shared reducer, output register.
module mexp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  mexp_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_power_result
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_BASE, S_ONE, S_MULT, S_SQR, S_OUT} t_st;
    t_st               r_st;
    logic [DATA_W-1:0] r_pw, r_acc, r_exp, r_m;
    logic [ECNT_W-1:0] r_cnt;
    logic              r_start;
    logic [DATA_W-1:0] r_a, r_b;
    logic              r_mul;
    logic              w_done;
    logic [DATA_W-1:0] w_r;

    mexp_reduce u_red (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_a(r_a), .i_b(r_b), .i_mul(r_mul), .i_m(r_m),
        .o_done(w_done), .o_r(w_r)
    );

    assign o_job_ready = (r_st == S_IDLE) && !o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_start <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_st)
                S_IDLE: if (i_job_valid && !o_valid) begin
                    if (i_job.zero_mod) begin
                        o_power_result <= '0;
                        o_valid        <= 1'b1;
                    end else begin
                        r_m <= i_job.modulus; r_exp <= i_job.expo;
                        r_cnt <= ECNT_W'(EXP_BITS);
                        r_a <= i_job.base; r_mul <= 1'b0; r_start <= 1'b1;
                        r_st <= S_BASE;
                    end
                end
                S_BASE: if (w_done) begin
                    r_pw <= w_r;
                    r_a <= DATA_W'(1); r_mul <= 1'b0; r_start <= 1'b1;
                    r_st <= S_ONE;
                end
                S_ONE, S_MULT: if (w_done) begin
                    r_acc <= w_r;
                    r_a <= r_pw; r_b <= r_pw; r_mul <= 1'b1; r_start <= 1'b1;
                    r_st <= S_SQR;
                    if (r_st == S_ONE && r_exp[0]) begin
                        r_a <= w_r; r_b <= r_pw; r_st <= S_MULT;
                    end
                end
                S_SQR: if (w_done) begin
                    r_pw  <= w_r;
                    r_exp <= r_exp >> 1;
                    r_cnt <= r_cnt - ECNT_W'(1);
                    if (r_cnt == ECNT_W'(1)) begin
                        r_st <= S_OUT;
                    end else if (r_exp[1]) begin
                        r_a <= r_acc; r_b <= w_r; r_mul <= 1'b1; r_start <= 1'b1;
                        r_st <= S_MULT;
                    end else begin
                        r_a <= w_r; r_b <= w_r; r_mul <= 1'b1; r_start <= 1'b1;
                    end
                end
                S_OUT: if (!o_valid) begin
                    o_power_result <= r_acc;
                    o_valid        <= 1'b1;
                    r_st           <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/modular_exponentiation.sv @@
// Top level of the modular exponentiation block.
// Computes base^exponent mod modulus, one result word per input word; a zero
// modulus gives 0. A two-word queue takes input words while the sequencer
// works. Each modular product uses one shared reducer: a multiply step, then a
// bit-serial restoring remainder over the 64-bit product. A word needs two
// reductions to set up plus one square per exponent bit and one multiply per
// set bit. A zero modulus returns its 0 result without using the reducer.
module modular_exponentiation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_base_value,
    input  logic [31:0] i_exponent_value,
    input  logic [31:0] i_modulus_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_power_result
);
    import mexp_pkg::*;

    t_job w_job;
    logic w_job_valid, w_job_ready;

    mexp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_base_value(i_base_value), .i_exponent_value(i_exponent_value),
        .i_modulus_value(i_modulus_value),
        .o_job_valid(w_job_valid), .i_job_ready(w_job_ready), .o_job(w_job)
    );

    mexp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_job_valid), .o_job_ready(w_job_ready), .i_job(w_job),
        .o_valid(o_valid), .i_ready(i_ready), .o_power_result(o_power_result)
    );
endmodule

@@ tb/mexp_checker.sv @@
// Checker for the modular exponentiation block: predicts and compares result words.
module mexp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [31:0] i_base_value,
    input  logic [31:0] i_exponent_value,
    input  logic [31:0] i_modulus_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_power_result,
    output int          o_fail_count,
    output int          o_pending
);
    import mexp_pkg::*;

    logic [31:0] power_q[$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending    = power_q.size();

    function automatic logic [31:0] mod_power(logic [31:0] b, logic [31:0] e,
                                              logic [31:0] m);
        logic [63:0] mm;
        logic [63:0] pw;
        logic [63:0] acc;
        mm = 64'(m) & ((64'd1 << MOD_BITS) - 64'd1);
        if (mm == 0) return '0;
        pw  = 64'(b) % mm;
        acc = 64'd1 % mm;
        for (int i = 0; i < EXP_BITS; i++) begin
            if (i < 32 && e[i]) acc = (acc * pw) % mm;
            pw = (pw * pw) % mm;
        end
        return acc[31:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fails++;
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && i_ready_in)
                power_q.insert(power_q.size(),
                               mod_power(i_base_value, i_exponent_value,
                                         i_modulus_value));
            if (i_out_valid && i_out_ready) begin
                if (power_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", i_power_result));
                end else if (power_q[0] !== i_power_result) begin
                    report_mismatch($sformatf("power_result got %h exp %h",
                                              i_power_result, power_q[0]));
                    void'(power_q.pop_front());
                end else begin
                    void'(power_q.pop_front());
                end
            end
        end
    end
endmodule

@@ tb/tb_modular_exponentiation.sv @@
// Testbench top for the modular exponentiation block: stimulus and verdict.
module tb_modular_exponentiation;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [31:0] i_base_value = 0;
    logic [31:0] i_exponent_value = 0;
    logic [31:0] i_modulus_value = 1;
    logic        o_valid;
    logic        i_ready = 0;
    logic [31:0] o_power_result;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          calm = 0;

    localparam int LIMIT = 4_000_000;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    modular_exponentiation dut (.*);

    mexp_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_base_value(i_base_value), .i_exponent_value(i_exponent_value),
        .i_modulus_value(i_modulus_value), .i_out_valid(o_valid),
        .i_out_ready(i_ready), .i_power_result(o_power_result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[modular_exponentiation] ERROR");
            $finish;
        end
    end

    // receiver stalls
    initial begin
        int n;
        @(negedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 0;
                n = $urandom_range(1, 11);
                repeat (n) @(negedge i_clk);
            end else begin
                i_ready <= 1;
                n = $urandom_range(1, 20);
                repeat (n) @(negedge i_clk);
            end
        end
    end

    task automatic send_word(logic [31:0] b, logic [31:0] e, logic [31:0] m);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            n = $urandom_range(1, 11);
            repeat (n) @(negedge i_clk);
        end
        i_valid          <= 1;
        i_base_value     <= b;
        i_exponent_value <= e;
        i_modulus_value  <= m;
        while (!o_ready) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] m;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_word(32'd5, 32'd0, 32'd7);
        send_word(32'd5, 32'd0, 32'd1);
        send_word(32'd12345, 32'd1, 32'd97);
        send_word(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'd0, 32'd0, 32'd13);
        send_word(32'd0, 32'd9, 32'd13);
        send_word(32'd3, 32'd200, 32'd0);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
        send_word(32'd2, 32'd31, 32'hFFFF_FFFB);
        send_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
        send_word(32'hAAAA_AAAA, 32'h5555_5555, 32'd2);
        for (int i = 0; i < 127; i++) begin
            if (i > 105) calm = 1;
            m = rand_word();
            if ($urandom_range(0, 30) == 0) m = 0;
            send_word(rand_word(), rand_word(), m);
        end
        i_valid <= 0;
        calm = 1;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("[modular_exponentiation] OK");
        else
            $display("[modular_exponentiation] ERROR");
        $finish;
    end
endmodule

@@ sim.f @@
sv/mexp_pkg.sv
sv/mexp_front.sv
sv/mexp_reduce.sv
sv/mexp_back.sv
sv/modular_exponentiation.sv
tb/mexp_checker.sv
tb/tb_modular_exponentiation.sv
